@@ hw/rtl/adq_pkg.sv @@
// Package for the array double-ended queue: operation and status codes,
// field widths, default sizes and the controller/datapath interface structs.
// No dependencies.
package adq_pkg;

    localparam int DATA_W    = 32;
    localparam int OP_W      = 2;
    localparam int STAT_W    = 2;
    localparam int CAP_W     = 6;
    localparam int DEPTH_DEF = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

    localparam logic [OP_W-1:0] OP_PUSH_REAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 2'd1;
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 2'd2;
    localparam logic [OP_W-1:0] OP_POP_REAR   = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd2;

    typedef struct packed {
        logic exec;
        logic load_rd;
    } t_cmd;

    typedef struct packed {
        logic need_read;
    } t_sts;

endpackage

@@ hw/rtl/adq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module adq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hw/rtl/adq_ctrl.sv @@
// Controller state machine of the double-ended queue: sequences accept,
// memory read and result delivery. Depends on adq_pkg.
module adq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    input  logic          i_m_tready,
    input  adq_pkg::t_sts i_sts,
    output logic          o_s_tready,
    output logic          o_m_tvalid,
    output adq_pkg::t_cmd o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state       = r_state;
        o_s_tready    = 1'b0;
        o_m_tvalid    = 1'b0;
        o_cmd.exec    = 1'b0;
        o_cmd.load_rd = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.exec = 1'b1;
                    n_state    = i_sts.need_read ? S_READ : S_OUT;
                end
            end
            S_READ: begin
                o_cmd.load_rd = 1'b1;
                n_state       = S_OUT;
            end
            S_OUT: begin
                o_m_tvalid = 1'b1;
                if (i_m_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ hw/rtl/adq_dp.sv @@
// Datapath of the double-ended queue: capacity register, head and tail
// pointers, slot memory and result register. Depends on adq_pkg and adq_ram.
module adq_dp #(
    parameter int DEPTH = adq_pkg::DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic        [adq_pkg::CAP_W-1:0]  i_cfg_wdata,
    input  logic        [adq_pkg::OP_W-1:0]   i_op,
    input  logic signed [adq_pkg::DATA_W-1:0] i_value_in,
    input  adq_pkg::t_cmd                     i_cmd,
    output adq_pkg::t_sts                     o_sts,
    output logic signed [adq_pkg::DATA_W-1:0] o_value_out,
    output logic        [adq_pkg::STAT_W-1:0] o_status
);

    localparam int AW = $clog2(DEPTH);
    localparam int UW = (AW + 1 > adq_pkg::CAP_W + 1) ? AW + 1 : adq_pkg::CAP_W + 1;

    logic [adq_pkg::CAP_W-1:0]  r_cap;
    logic [AW-1:0]              r_head;
    logic [AW-1:0]              n_head;
    logic [AW-1:0]              r_tail;
    logic [AW-1:0]              n_tail;
    logic                       r_empty;
    logic                       n_empty;
    logic signed [adq_pkg::DATA_W-1:0] r_value;
    logic [adq_pkg::STAT_W-1:0] r_status;

    logic [UW-1:0]              cap_ext;
    logic [UW-1:0]              usable;
    logic [UW-1:0]              tail_inc;
    logic                       wr_en;
    logic [AW-1:0]              wr_addr;
    logic                       rd_en;
    logic [AW-1:0]              rd_addr;
    logic [adq_pkg::DATA_W-1:0] rd_data;
    logic [adq_pkg::STAT_W-1:0] status;
    logic                       need_read;

    assign cap_ext  = UW'(r_cap);
    assign tail_inc = UW'(r_tail) + UW'(1);

    always_comb begin
        if (cap_ext == '0) begin
            usable = UW'(1);
        end else if (cap_ext > UW'(DEPTH)) begin
            usable = UW'(DEPTH);
        end else begin
            usable = cap_ext;
        end
    end

    always_comb begin
        n_head    = r_head;
        n_tail    = r_tail;
        n_empty   = r_empty;
        wr_en     = 1'b0;
        wr_addr   = '0;
        rd_addr   = r_head;
        status    = adq_pkg::ST_OK;
        need_read = 1'b0;
        case (i_op)
            adq_pkg::OP_PUSH_REAR, adq_pkg::OP_PUSH_FRONT: begin
                if (r_empty) begin
                    n_head  = '0;
                    n_tail  = '0;
                    n_empty = 1'b0;
                    wr_en   = 1'b1;
                end else if (i_op == adq_pkg::OP_PUSH_REAR) begin
                    if (tail_inc >= usable) begin
                        status = adq_pkg::ST_OVERFLOW;
                    end else begin
                        n_tail  = r_tail + AW'(1);
                        wr_en   = 1'b1;
                        wr_addr = r_tail + AW'(1);
                    end
                end else begin
                    if (r_head == '0) begin
                        status = adq_pkg::ST_OVERFLOW;
                    end else begin
                        n_head  = r_head - AW'(1);
                        wr_en   = 1'b1;
                        wr_addr = r_head - AW'(1);
                    end
                end
            end
            adq_pkg::OP_POP_FRONT, adq_pkg::OP_POP_REAR: begin
                if (r_empty) begin
                    status = adq_pkg::ST_UNDERFLOW;
                end else begin
                    need_read = 1'b1;
                    rd_addr   = (i_op == adq_pkg::OP_POP_FRONT) ? r_head : r_tail;
                    if (r_head == r_tail) begin
                        n_head  = '0;
                        n_tail  = '0;
                        n_empty = 1'b1;
                    end else if (i_op == adq_pkg::OP_POP_FRONT) begin
                        n_head = r_head + AW'(1);
                    end else begin
                        n_tail = r_tail - AW'(1);
                    end
                end
            end
            default: begin
                status = adq_pkg::ST_OK;
            end
        endcase
    end

    assign o_sts.need_read = need_read;
    assign rd_en           = i_cmd.exec && need_read;

    adq_ram #(
        .WIDTH (adq_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.exec && wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_value_in),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= adq_pkg::CAP_RESET;
            r_head  <= '0;
            r_tail  <= '0;
            r_empty <= 1'b1;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (i_cmd.exec) begin
                r_head  <= n_head;
                r_tail  <= n_tail;
                r_empty <= n_empty;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_value  <= '0;
            r_status <= status;
        end else if (i_cmd.load_rd) begin
            r_value <= rd_data;
        end
    end

    assign o_value_out = r_value;
    assign o_status    = r_status;

endmodule

@@ hw/rtl/array_double_ended_queue_core.sv @@
// Top level of the array double-ended queue: joins controller and datapath.
// Depends on adq_pkg, adq_ctrl, adq_dp and adq_ram.
//
//   Channel   Direction  Payload
//   s_*       in         tuser = op[1:0], tdata = value_in[31:0]
//   m_*       out        tuser = status[1:0], tdata = value_out[31:0]
//   cfg       in         i_cfg_wdata = capacity[5:0], written when i_cfg_we
//
// One transaction at a time: a push, or a pop that finds the queue empty, goes through
// accept, then result; a successful pop goes through accept, registered slot memory
// read, then result. The next transaction is accepted in the cycle after the
// result is taken.
// Reset is synchronous and active low; it empties the queue and sets capacity to 32.
// A stalled result holds until i_m_tready; the slot memory has no reset.
module array_double_ended_queue_core #(
    parameter int DEPTH = adq_pkg::DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic signed [adq_pkg::DATA_W-1:0] i_s_tdata,   // [31:0] value_in
    input  logic        [adq_pkg::OP_W-1:0]   i_s_tuser,   // [1:0] op
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic signed [adq_pkg::DATA_W-1:0] o_m_tdata,   // [31:0] value_out
    output logic        [adq_pkg::STAT_W-1:0] o_m_tuser,   // [1:0] status
    input  logic                              i_cfg_we,
    input  logic        [adq_pkg::CAP_W-1:0]  i_cfg_wdata
);

    adq_pkg::t_cmd cmd;
    adq_pkg::t_sts sts;

    adq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_m_tready (i_m_tready),
        .i_sts      (sts),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_cmd      (cmd)
    );

    adq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_op        (i_s_tuser),
        .i_value_in  (i_s_tdata),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_value_out (o_m_tdata),
        .o_status    (o_m_tuser)
    );

`ifndef NO_ASSERTIONS
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_tready && o_m_tvalid))
        else $error("input accepted while a result is pending");

    a_push_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && !i_s_tuser[0])
        |=> (o_m_tvalid && o_m_tuser != adq_pkg::ST_UNDERFLOW))
        else $error("push did not give a result in the next cycle");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser != adq_pkg::ST_OK) |-> (o_m_tdata == '0))
        else $error("failed transaction returned nonzero data");
`endif

endmodule
